// File: hw/rtl/rmed5_pkg.sv
// shared constants, types and control structs of the multichannel running median unit
`default_nettype none

package rmed5_pkg;

  localparam int CHANNELS = 17;
  localparam int WINDOW   = 5;
  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = $clog2(WINDOW);
  localparam int MID      = WINDOW / 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [CHAN_W-1:0]           chan_t;
  typedef logic [SAMPLE_W-1:0]         sample_t;
  typedef logic [POS_W-1:0]            pos_t;
  typedef logic [CH_IDX_W-1:0]         ch_idx_t;
  typedef sample_t [WINDOW-1:0]        window_t;

  // per-channel state as read for the item at work
  typedef struct packed {
    window_t win;
    pos_t    pos;
    sample_t filt;
  } chan_rd_t;

  // per-channel state write-back
  typedef struct packed {
    logic    en;
    ch_idx_t ch;
    window_t win;
    pos_t    pos;
    sample_t filt;
  } chan_upd_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmed5_if.sv
// valid/ready channel interfaces for sample words and median words
`default_nettype none

interface rmed5_in_if;
  logic                   valid;
  logic                   ready;
  rmed5_pkg::chan_t       channel;
  rmed5_pkg::sample_t     sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface rmed5_out_if;
  logic                   valid;
  logic                   ready;
  rmed5_pkg::sample_t     median;
  logic                   changed;

  modport source (output valid, output median, output changed, input ready);
  modport sink   (input valid, input median, input changed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rmed5_window_median.sv
// rank-count compare network that picks the middle element of one window
`default_nettype none

module rmed5_window_median (
  input  wire rmed5_pkg::window_t win,
  output rmed5_pkg::sample_t median
);

  rmed5_pkg::pos_t rank [rmed5_pkg::WINDOW];

  // rank of each element, ties broken by lane so ranks form a permutation
  always_comb begin
    for (int i = 0; i < rmed5_pkg::WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < rmed5_pkg::WINDOW; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + rmed5_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  // exactly one lane holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < rmed5_pkg::WINDOW; i++) begin
      if (rank[i] == rmed5_pkg::POS_W'(rmed5_pkg::MID)) begin
        median = median | win[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmed5_channel_state.sv
// per-channel sample rings, write positions and filtered values
`default_nettype none

module rmed5_channel_state (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire rmed5_pkg::ch_idx_t   rd_ch,
  output rmed5_pkg::chan_rd_t    rd,
  input  wire rmed5_pkg::chan_upd_t upd
);

  rmed5_pkg::window_t win_r  [rmed5_pkg::CHANNELS];
  rmed5_pkg::pos_t    pos_r  [rmed5_pkg::CHANNELS];
  rmed5_pkg::sample_t filt_r [rmed5_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < rmed5_pkg::CHANNELS; c++) begin
        win_r[c]  <= '0;
        pos_r[c]  <= '0;
        filt_r[c] <= '0;
      end
    end else if (upd.en) begin
      win_r[upd.ch]  <= upd.win;
      pos_r[upd.ch]  <= upd.pos;
      filt_r[upd.ch] <= upd.filt;
    end
  end

  // caller only uses the read when the channel is in range
  always_comb begin
    rd.win  = win_r[rd_ch];
    rd.pos  = pos_r[rd_ch];
    rd.filt = filt_r[rd_ch];
  end

endmodule

`default_nettype wire

// File: hw/rtl/multichannel_running_median5_unit.sv
// top level: multichannel running median filter with input and result registers
// a word accepted on in passes the input register and then the result register before it shows on out
// throughput: one word per cycle while out takes results, set by the combinational window update and median network
// the input register doubles as the skid stage while a result waits on out
// reset (rst_n low, synchronous) empties both registers and zeroes all rings,
// write positions and filtered values
`default_nettype none

module multichannel_running_median5_unit (
  input  wire              clk,
  input  wire              rst_n,
  rmed5_in_if.sink         in_if,
  rmed5_out_if.source      out_if
);

  // input register
  logic                 in_valid_r;
  logic                 in_valid_nxt;
  rmed5_pkg::chan_t     chan_r;
  rmed5_pkg::sample_t   sample_r;

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rmed5_pkg::sample_t   out_median_r;
  logic                 out_changed_r;

  // work stage
  logic                 in_take;
  logic                 fire;
  logic                 in_range;
  rmed5_pkg::ch_idx_t   ch_idx;
  rmed5_pkg::chan_rd_t  rd;
  rmed5_pkg::chan_upd_t upd;
  rmed5_pkg::pos_t      wpos;
  rmed5_pkg::pos_t      pos_next;
  rmed5_pkg::window_t   win_new;
  rmed5_pkg::sample_t   med;

  // handshake: work proceeds when the result register is free or draining
  assign fire         = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || fire;
  assign in_take      = in_if.valid && in_if.ready;

  assign in_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      chan_r   <= in_if.channel;
      sample_r <= in_if.sample;
    end
    if (fire) begin
      out_median_r  <= in_range ? med : '0;
      out_changed_r <= in_range && (sample_r != rd.filt);
    end
  end

  // channels at or above the channel count leave state alone and answer zero
  assign in_range = (32'(chan_r) < rmed5_pkg::CHANNELS);
  assign ch_idx   = chan_r[rmed5_pkg::CH_IDX_W-1:0];

  rmed5_channel_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_ch (ch_idx),
    .rd    (rd),
    .upd   (upd)
  );

  // overwrite the oldest slot, then advance the ring position
  always_comb begin
    wpos = (32'(rd.pos) >= rmed5_pkg::WINDOW) ? '0 : rd.pos;
    pos_next = (32'(wpos) == rmed5_pkg::WINDOW - 1) ? '0 : wpos + rmed5_pkg::POS_W'(1);
    for (int i = 0; i < rmed5_pkg::WINDOW; i++) begin
      win_new[i] = (rmed5_pkg::POS_W'(i) == wpos) ? sample_r : rd.win[i];
    end
  end

  rmed5_window_median u_median (
    .win    (win_new),
    .median (med)
  );

  // state write-back happens at the same edge as the result load,
  // so the next word for this channel already sees the new ring
  always_comb begin
    upd.en   = fire && in_range;
    upd.ch   = ch_idx;
    upd.win  = win_new;
    upd.pos  = pos_next;
    upd.filt = med;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.median  = out_median_r;
  assign out_if.changed = out_changed_r;

  // every word taken into the work stage lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach result register");

  // out-of-range channel answers zero
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_range) |=> (out_median_r == '0) && !out_changed_r)
    else $error("out-of-range channel gave nonzero result");

  // a held word in the input register is not overwritten
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |=> in_valid_r && $stable(chan_r) && $stable(sample_r))
    else $error("stalled input word was lost");

  // stalled result keeps its value
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> out_valid_r && $stable(out_median_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: bench/median_check_pkg.sv
// predictor and result scoreboard for the multichannel running median unit
package median_check_pkg;
  import rmed5_pkg::*;

  typedef struct {
    sample_t median;
    logic    changed;
  } median_word_t;

  class median_scoreboard;
    sample_t      ring[CHANNELS][WINDOW];
    pos_t         wr_pos[CHANNELS];
    sample_t      filt[CHANNELS];
    median_word_t pending_medians[$];
    int           failures;

    function new();
      foreach (ring[c, k]) ring[c][k] = '0;
      foreach (wr_pos[c]) begin
        wr_pos[c] = '0;
        filt[c]   = '0;
      end
      failures = 0;
    endfunction

    // a value is the middle one when at most MID values lie below it
    // and more than MID lie at or below it, so duplicates count
    function sample_t window_middle(int c);
      int below;
      int not_above;
      for (int i = 0; i < WINDOW; i++) begin
        below     = 0;
        not_above = 0;
        for (int j = 0; j < WINDOW; j++) begin
          if (ring[c][j] < ring[c][i]) below++;
          if (ring[c][j] <= ring[c][i]) not_above++;
        end
        if (below <= MID && not_above > MID) return ring[c][i];
      end
      return '0;
    endfunction

    function sample_t filtered_of(chan_t ch);
      if (int'(ch) >= CHANNELS) return '0;
      return filt[int'(ch)];
    endfunction

    function int pending();
      return pending_medians.size();
    endfunction

    function void note_sample(chan_t ch, sample_t s);
      median_word_t w;
      int           c;
      c = int'(ch);
      if (c >= CHANNELS) begin
        // unknown channel: zero word, nothing stored
        w.median  = '0;
        w.changed = 1'b0;
      end else begin
        w.changed = (s != filt[c]);
        ring[c][wr_pos[c]] = s;
        wr_pos[c] = (wr_pos[c] == pos_t'(WINDOW - 1)) ? '0 : wr_pos[c] + 1'b1;
        w.median  = window_middle(c);
        filt[c]   = w.median;
      end
      pending_medians.push_back(w);
    endfunction

    function void check_result(sample_t med, logic chg);
      median_word_t w;
      if (pending_medians.size() == 0) begin
        failures++;
        $error("unexpected result word: median %0d changed %0b", med, chg);
        return;
      end
      w = pending_medians.pop_front();
      if (med !== w.median) begin
        failures++;
        $error("median: expected %0d, got %0d", w.median, med);
      end
      if (chg !== w.changed) begin
        failures++;
        $error("changed: expected %0b, got %0b", w.changed, chg);
      end
    endfunction
  endclass
endpackage

// File: bench/multichannel_running_median5_unit_test.sv
// top-level testbench of the multichannel running median unit
module multichannel_running_median5_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmed5_pkg::*;
  import median_check_pkg::*;

  logic clk;
  logic rst_n;

  rmed5_in_if  in_bus();
  rmed5_out_if out_bus();

  multichannel_running_median5_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  median_scoreboard sb;

  // idling odds in percent, changed per phase by the main sequence
  int idle_pct  = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs on a handshake
  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: ready redrawn every cycle, stall odds from stall_pct
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // both monitors sample at the rising edge; a word accepted on in must pass
  // the input and result registers to reach out, so noting before checking is safe
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      sb.note_sample(in_bus.channel, in_bus.sample);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result(out_bus.median, out_bus.changed);
    end
  end

  // sender: called at a falling edge, returns at the falling edge after
  // the word went through, so back-to-back words keep valid high
  task automatic send_word(input chan_t ch, input sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= s;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // mostly valid channels, now and then one at or above the channel count, up to 31
  function automatic chan_t pick_channel();
    if ($urandom_range(99) < 88) return chan_t'($urandom_range(CHANNELS - 1));
    return chan_t'($urandom_range(31, CHANNELS));
  endfunction

  // mix of full-range values, repeats of the current filtered value (to get
  // changed low), tiny values that pile up duplicates, the rails and filtered +/- 1
  function automatic sample_t pick_sample(chan_t ch);
    int mode;
    mode = $urandom_range(99);
    if (mode < 40) return sample_t'($urandom_range(65535));
    if (mode < 60) return sb.filtered_of(ch);
    if (mode < 85) return sample_t'($urandom_range(3));
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return sb.filtered_of(ch) + sample_t'($urandom_range(2)) - 1'b1;
    endcase
  endfunction

  initial begin
    chan_t ch;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.channel = '0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    sb = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words on a fresh channel 0: zero against the cleared
    // filtered value leaves changed low, then the rails fill the ring
    send_word(chan_t'(0), 16'h0000);
    send_word(chan_t'(0), 16'hFFFF);
    send_word(chan_t'(0), 16'hFFFF);
    send_word(chan_t'(0), 16'hFFFF);
    // ring wraps here, and the sample matches the filtered value
    send_word(chan_t'(0), 16'hFFFF);
    send_word(chan_t'(0), 16'h0001);
    // last channel with alternating bit patterns, wrap and a duplicate
    send_word(chan_t'(CHANNELS - 1), 16'h8000);
    send_word(chan_t'(CHANNELS - 1), 16'h7FFF);
    send_word(chan_t'(CHANNELS - 1), 16'h5555);
    send_word(chan_t'(CHANNELS - 1), 16'hAAAA);
    send_word(chan_t'(CHANNELS - 1), 16'h1234);
    send_word(chan_t'(CHANNELS - 1), 16'h1234);
    // channels out of range give a zero word and store nothing
    send_word(chan_t'(CHANNELS), 16'hFFFF);
    send_word(chan_t'(31), 16'hAAAA);
    send_word(chan_t'(21), 16'h5555);
    // equal values on a middle channel
    send_word(chan_t'(8), 16'd42);
    send_word(chan_t'(8), 16'd42);
    send_word(chan_t'(8), 16'd42);
    send_word(chan_t'(8), 16'd42);
    send_word(chan_t'(8), 16'd7);
    // other channels must be untouched by the out-of-range words
    send_word(chan_t'(1), 16'h0000);
    send_word(chan_t'(CHANNELS - 1), 16'hFFFF);

    // random words in four idling phases: none, sender idle,
    // receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < 200; n++) begin
        ch = pick_channel();
        send_word(ch, pick_sample(ch));
      end
    end
    in_bus.valid <= 1'b0;

    // drain, then give a stray word time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
